[hdl/cgs_pkg.sv]
// Shared types and constants for the causal normalized Gaussian smoother.
// No dependencies; every other file of the block imports this package.
package cgs_pkg;

    localparam int OPCODE_BITS    = 2;
    localparam int TAP_INDEX_BITS = 5;
    localparam int CFG_BITS       = 6;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_LOAD    = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_TAIL    = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ACCUM,
        ST_START,
        ST_DIV,
        ST_PUSH
    } state_t;

    // Control broadcast from the sequencer to every cell of the tap chain.
    typedef struct packed {
        logic                      shift;
        logic                      clear;
        logic                      load_terms;
        logic                      move_terms;
        logic                      wr_en;
        logic [TAP_INDEX_BITS-1:0] wr_index;
    } cell_ctrl_t;

endpackage

[hdl/causal_normalized_gaussian_smoother.sv]
// Top level of the causal normalized Gaussian smoother: sequencer, tap chain,
// accumulator and output register. Depends on cgs_pkg, cgs_cell and cgs_div.
//
//   Channel   Ports                                         Direction
//   input     s_valid s_ready s_opcode s_tap_index
//             s_tap_weight s_sample                         in (ready out)
//   result    m_valid m_ready m_smoothed m_from_tail        out (ready in)
//   config    cfg_valid cfg_ready cfg_data (tap_count)      in (ready out)
//
// Weight loads and restarts are handled in the idle state. In a sample or tail
// step the product terms shift through the tap chain into the accumulator one
// tap a cycle, then the bit-serial divider for the normalization yields
// one quotient bit a cycle. Reset is synchronous and active low; it clears the
// history and sets tap_count to 1, while tap weights hold garbage until loaded.
// A stalled result waits in the output register and a following item is still
// accepted; only a second result has to wait for it.
module causal_normalized_gaussian_smoother #(
    parameter int MAX_TAPS    = 32,
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [cgs_pkg::OPCODE_BITS-1:0]    s_opcode,
    input  logic [cgs_pkg::TAP_INDEX_BITS-1:0] s_tap_index,
    input  logic [WEIGHT_BITS-1:0]             s_tap_weight,
    input  logic [SAMPLE_BITS-1:0]             s_sample,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [SAMPLE_BITS-1:0]             m_smoothed,
    output logic                               m_from_tail,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cgs_pkg::CFG_BITS-1:0]       cfg_data
);
    import cgs_pkg::*;

    localparam int TAP_W  = $clog2(MAX_TAPS + 1);
    localparam int CNT_W  = (TAP_W > CFG_BITS) ? TAP_W : CFG_BITS;
    localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS;
    localparam int NORM_W = WEIGHT_BITS + $clog2(MAX_TAPS);
    localparam int SUM_W  = NORM_W + SAMPLE_BITS;

    state_t                 state_reg, state_next;
    cell_ctrl_t             ctrl;
    op_t                    op;
    logic                   s_xfer;
    logic                   out_free;
    logic                   div_start;
    logic                   div_done;
    logic [SAMPLE_BITS-1:0] div_quo;

    logic [TAP_W-1:0]       taps_reg, taps_next;
    logic [CNT_W-1:0]       cfg_ext;
    logic [TAP_W-1:0]       acc_cnt_reg, acc_cnt_next;
    logic [SUM_W-1:0]       acc_sum_reg, acc_sum_next;
    logic [NORM_W-1:0]      acc_norm_reg, acc_norm_next;
    logic                   tail_reg;
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_smoothed_reg;
    logic                   m_from_tail_reg;

    logic [SAMPLE_BITS-1:0] value_w   [MAX_TAPS+1];
    logic                   present_w [MAX_TAPS+1];
    logic [PROD_W-1:0]      prod_w    [MAX_TAPS+1];
    logic [WEIGHT_BITS-1:0] wt_w      [MAX_TAPS+1];

    assign op       = op_t'(s_opcode);
    assign s_xfer   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Configuration: store the clamped tap count.
    assign cfg_ready = 1'b1;
    assign cfg_ext   = CNT_W'(cfg_data);

    always_comb begin
        if (cfg_ext == '0) begin
            taps_next = TAP_W'(1);
        end else if (cfg_ext > CNT_W'(MAX_TAPS)) begin
            taps_next = TAP_W'(MAX_TAPS);
        end else begin
            taps_next = TAP_W'(cfg_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            taps_reg <= TAP_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            taps_reg <= taps_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (op == OP_SAMPLE || op == OP_TAIL)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (acc_cnt_reg == TAP_W'(1)) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        s_ready         = 1'b0;
        div_start       = 1'b0;
        ctrl.shift      = 1'b0;
        ctrl.clear      = 1'b0;
        ctrl.load_terms = 1'b0;
        ctrl.move_terms = 1'b0;
        ctrl.wr_en      = 1'b0;
        ctrl.wr_index   = s_tap_index;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                ctrl.shift = s_xfer && (op == OP_SAMPLE || op == OP_TAIL);
                ctrl.clear = s_xfer && (op == OP_RESTART);
                ctrl.wr_en = s_xfer && (op == OP_LOAD);
            end
            ST_LOAD: begin
                ctrl.load_terms = 1'b1;
            end
            ST_ACCUM: begin
                ctrl.move_terms = 1'b1;
            end
            ST_START: begin
                div_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Accumulator fed from the head of the chain.
    always_comb begin
        acc_cnt_next  = acc_cnt_reg;
        acc_sum_next  = acc_sum_reg;
        acc_norm_next = acc_norm_reg;
        if (state_reg == ST_LOAD) begin
            acc_cnt_next  = taps_reg;
            acc_sum_next  = '0;
            acc_norm_next = '0;
        end else if (state_reg == ST_ACCUM) begin
            acc_cnt_next  = acc_cnt_reg - 1'b1;
            acc_sum_next  = acc_sum_reg + SUM_W'(prod_w[0]);
            acc_norm_next = acc_norm_reg + NORM_W'(wt_w[0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_cnt_reg <= '0;
        end else begin
            acc_cnt_reg <= acc_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_sum_reg  <= acc_sum_next;
        acc_norm_reg <= acc_norm_next;
        if (ctrl.shift) begin
            tail_reg <= (op == OP_TAIL);
        end
    end

    // Tap chain: history moves away from tap 0, terms move toward it.
    assign value_w[0]         = (op == OP_SAMPLE) ? s_sample : '0;
    assign present_w[0]       = (op == OP_SAMPLE);
    assign prod_w[MAX_TAPS]   = '0;
    assign wt_w[MAX_TAPS]     = '0;

    for (genvar i = 0; i < MAX_TAPS; i++) begin : g_tap
        cgs_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .WEIGHT_BITS (WEIGHT_BITS),
            .IDX         (i)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctrl        (ctrl),
            .wr_weight   (s_tap_weight),
            .value_in    (value_w[i]),
            .present_in  (present_w[i]),
            .value_out   (value_w[i+1]),
            .present_out (present_w[i+1]),
            .prod_in     (prod_w[i+1]),
            .wt_in       (wt_w[i+1]),
            .prod_out    (prod_w[i]),
            .wt_out      (wt_w[i])
        );
    end

    cgs_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .NORM_W      (NORM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_sum_reg),
        .divisor  (acc_norm_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_PUSH && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PUSH && out_free) begin
            m_smoothed_reg  <= div_quo;
            m_from_tail_reg <= tail_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_smoothed  = m_smoothed_reg;
    assign m_from_tail = m_from_tail_reg;

    // Checks on the sequencer and datapath.
    a_taps_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (taps_reg != '0) && (taps_reg <= TAP_W'(MAX_TAPS)))
        else $error("tap count register out of range");

    a_accum_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ACCUM) |-> (acc_cnt_reg != '0))
        else $error("accumulation running with zero taps left");

    a_div_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside the divide phase");

    a_step_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (op == OP_SAMPLE || op == OP_TAIL)) |=> (state_reg == ST_LOAD))
        else $error("sample or tail transfer did not start a computation");

    a_push_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH && out_free) |=> m_valid)
        else $error("result not presented after push");

endmodule

[hdl/cgs_cell.sv]
// One tap of the smoother chain: history entry, tap weight and product term.
// Depends on cgs_pkg for the control struct.
module cgs_cell #(
    parameter int SAMPLE_BITS = 16,
    parameter int WEIGHT_BITS = 16,
    parameter int IDX         = 0
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  cgs_pkg::cell_ctrl_t                ctrl,
    input  logic [WEIGHT_BITS-1:0]             wr_weight,
    input  logic [SAMPLE_BITS-1:0]             value_in,
    input  logic                               present_in,
    output logic [SAMPLE_BITS-1:0]             value_out,
    output logic                               present_out,
    input  logic [SAMPLE_BITS+WEIGHT_BITS-1:0] prod_in,
    input  logic [WEIGHT_BITS-1:0]             wt_in,
    output logic [SAMPLE_BITS+WEIGHT_BITS-1:0] prod_out,
    output logic [WEIGHT_BITS-1:0]             wt_out
);
    import cgs_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + WEIGHT_BITS;

    logic [SAMPLE_BITS-1:0] value_reg;
    logic                   present_reg;
    logic [WEIGHT_BITS-1:0] weight_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [WEIGHT_BITS-1:0] wt_reg;
    logic                   wr_hit;

    assign wr_hit = ctrl.wr_en && (32'(ctrl.wr_index) == IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg <= 1'b0;
        end else if (ctrl.clear) begin
            present_reg <= 1'b0;
        end else if (ctrl.shift) begin
            present_reg <= present_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            value_reg <= value_in;
        end
        if (wr_hit) begin
            weight_reg <= wr_weight;
        end
        // Terms are formed once per item, then walk toward tap 0 one cell a cycle.
        if (ctrl.load_terms) begin
            prod_reg <= present_reg ? PROD_W'(weight_reg) * PROD_W'(value_reg) : '0;
            wt_reg   <= present_reg ? weight_reg : '0;
        end else if (ctrl.move_terms) begin
            prod_reg <= prod_in;
            wt_reg   <= wt_in;
        end
    end

    assign value_out   = value_reg;
    assign present_out = present_reg;
    assign prod_out    = prod_reg;
    assign wt_out      = wt_reg;

endmodule

[hdl/cgs_div.sv]
// Bit-serial restoring divider for the normalization step, one quotient bit a cycle.
// Depends on cgs_pkg only by the house import convention.
module cgs_div #(
    parameter int SAMPLE_BITS = 16,
    parameter int NORM_W      = 21
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [NORM_W+SAMPLE_BITS-1:0] dividend,
    input  logic [NORM_W-1:0]             divisor,
    output logic                          done,
    output logic [SAMPLE_BITS-1:0]        quotient
);
    import cgs_pkg::*;

    localparam int SUM_W  = NORM_W + SAMPLE_BITS;
    localparam int DCNT_W = $clog2(SAMPLE_BITS + 1);

    logic [SUM_W-1:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]       dsr_reg, dsr_next;
    logic [SAMPLE_BITS-1:0] quo_reg, quo_next;
    logic [DCNT_W-1:0]      cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   zero_reg, zero_next;
    logic                   fits;

    // The weighted mean never exceeds the largest sample, so the quotient
    // fits in SAMPLE_BITS and the first trial divisor is divisor << (SAMPLE_BITS-1).
    assign fits = (rem_reg >= dsr_reg);

    always_comb begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = dividend;
            dsr_next  = SUM_W'(divisor) << (SAMPLE_BITS - 1);
            quo_next  = '0;
            cnt_next  = DCNT_W'(SAMPLE_BITS);
            busy_next = 1'b1;
            zero_next = (divisor == '0);
        end else if (busy_reg) begin
            if (fits) begin
                rem_next = rem_reg - dsr_reg;
            end
            quo_next = {quo_reg[SAMPLE_BITS-2:0], fits};
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dsr_reg  <= dsr_next;
        quo_reg  <= quo_next;
        zero_reg <= zero_next;
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : quo_reg;

endmodule

[tb/tb.sv]
// Self-checking testbench for causal_normalized_gaussian_smoother.
// Depends on cgs_pkg and the block's RTL; a clocked driver and monitor run the
// stream while an in-bench predictor of the smoothing filter checks each result.
`timescale 1ns / 1ps

module tb;
    import cgs_pkg::*;

    localparam int TAP_LIMIT      = 32;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int DRAIN_GAP      = 100;
    localparam int QUIET_LIMIT    = 4000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 140;
    localparam int PRESSURE_PHASE = 4;

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        op_t         opcode;
        logic [4:0]  tap_index;
        logic [15:0] tap_weight;
        logic [15:0] sample;
    } stream_item_t;

    typedef struct {
        logic [15:0] smoothed;
        logic        from_tail;
    } smooth_result_t;

    logic        aclk         = 1'b0;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode     = '0;
    logic [4:0]  s_tap_index  = '0;
    logic [15:0] s_tap_weight = '0;
    logic [15:0] s_sample     = '0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [15:0] m_smoothed;
    logic        m_from_tail;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data     = '0;

    // Predictor state: history with presence flags, tap weights, tap count.
    logic [15:0] hist_val [TAP_LIMIT];
    bit          hist_ok  [TAP_LIMIT];
    logic [15:0] tap_w    [TAP_LIMIT];
    logic [5:0]  model_taps = 6'd1;

    stream_item_t   stream_items [$];
    smooth_result_t smoothed_due [$];

    idle_mode_t idle_mode    = IDLE_NONE;
    int         cur_phase    = -1;
    int         accepted_cnt = 0;
    int         offer_cnt    = 0;
    int         results_seen = 0;
    int         zero_results = 0;
    int         tail_results = 0;
    int         cfg_writes   = 0;
    int         err_count    = 0;
    int         quiet        = 0;

    causal_normalized_gaussian_smoother dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_opcode    (s_opcode),
        .s_tap_index (s_tap_index),
        .s_tap_weight(s_tap_weight),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_smoothed  (m_smoothed),
        .m_from_tail (m_from_tail),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic stream_item_t make_item(op_t op, logic [4:0] idx, logic [15:0] w,
                                               logic [15:0] smp);
        stream_item_t it;
        it.opcode     = op;
        it.tap_index  = idx;
        it.tap_weight = w;
        it.sample     = smp;
        return it;
    endfunction

    // Appends an item to the tail of the pending stream.
    function automatic void queue_item(stream_item_t it);
        stream_items.insert(stream_items.size(), it);
    endfunction

    // Appends a predicted result to the tail of the expected list.
    function automatic void expect_result(logic [15:0] smoothed, logic from_tail);
        smooth_result_t r;
        r.smoothed  = smoothed;
        r.from_tail = from_tail;
        smoothed_due.insert(smoothed_due.size(), r);
    endfunction

    function automatic void shift_history(logic [15:0] v, bit ok);
        for (int k = TAP_LIMIT - 1; k > 0; k--) begin
            hist_val[k] = hist_val[k-1];
            hist_ok[k]  = hist_ok[k-1];
        end
        hist_val[0] = v;
        hist_ok[0]  = ok;
    endfunction

    // Normalized weighted sum over the present entries within the active taps.
    function automatic logic [15:0] weighted_mean();
        longint unsigned acc;
        longint unsigned norm;
        int              span;
        acc  = 0;
        norm = 0;
        span = (model_taps == 0) ? 1 : ((model_taps > TAP_LIMIT) ? TAP_LIMIT : model_taps);
        for (int k = 0; k < span; k++) begin
            if (hist_ok[k]) begin
                acc  += 64'(tap_w[k]) * 64'(hist_val[k]);
                norm += 64'(tap_w[k]);
            end
        end
        return (norm == 0) ? 16'd0 : 16'(acc / norm);
    endfunction

    // Sender: a new item goes on the bus only once the previous one has transferred.
    always @(negedge aclk) begin : drive_stream
        stream_item_t nxt;
        bit           hold;
        hold = (idle_mode == IDLE_SENDER && $urandom_range(0, 99) < 52) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 19);
        if (!s_valid || accepted_cnt == offer_cnt) begin
            if (aresetn && stream_items.size() != 0 && !hold) begin
                nxt          = stream_items.pop_front();
                s_opcode     <= nxt.opcode;
                s_tap_index  <= nxt.tap_index;
                s_tap_weight <= nxt.tap_weight;
                s_sample     <= nxt.sample;
                s_valid      <= 1'b1;
                offer_cnt++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off in the pressure phase.
    always @(negedge aclk) begin : drive_ready
        int holdoff_left;
        bit holdoff_done;
        bit stall;
        if (cur_phase == PRESSURE_PHASE && !holdoff_done) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_done = 1'b1;
        end
        stall = (idle_mode == IDLE_RECEIVER && $urandom_range(0, 99) < 52) ||
                (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 19);
        if (holdoff_left > 0) begin
            holdoff_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !stall;
        end
    end

    // Monitor: checks results against the oldest prediction, then predicts from
    // the input transfer of the same edge, and runs the watchdog.
    always @(posedge aclk) begin : watch_ports
        smooth_result_t want;
        bit             moved;
        moved = 1'b0;
        if (aresetn && m_valid && m_ready) begin
            moved = 1'b1;
            results_seen++;
            if (smoothed_due.size() == 0) begin
                $error("unexpected result: smoothed %0d from_tail %0d", m_smoothed, m_from_tail);
                err_count++;
            end else begin
                want = smoothed_due.pop_front();
                if (m_smoothed !== want.smoothed) begin
                    $error("smoothed mismatch: expected %0d, actual %0d",
                           want.smoothed, m_smoothed);
                    err_count++;
                end
                if (m_from_tail !== want.from_tail) begin
                    $error("from_tail mismatch: expected %0d, actual %0d",
                           want.from_tail, m_from_tail);
                    err_count++;
                end
                if (want.smoothed == 0) zero_results++;
                if (want.from_tail) tail_results++;
            end
        end
        if (aresetn && s_valid && s_ready) begin
            moved = 1'b1;
            accepted_cnt++;
            case (op_t'(s_opcode))
                OP_LOAD: begin
                    tap_w[s_tap_index] = s_tap_weight;
                end
                OP_SAMPLE: begin
                    shift_history(s_sample, 1'b1);
                    expect_result(weighted_mean(), 1'b0);
                end
                OP_TAIL: begin
                    shift_history(16'd0, 1'b0);
                    expect_result(weighted_mean(), 1'b1);
                end
                default: begin
                    for (int k = 0; k < TAP_LIMIT; k++) begin
                        hist_val[k] = '0;
                        hist_ok[k]  = 1'b0;
                    end
                end
            endcase
        end
        if (aresetn && cfg_valid && cfg_ready) moved = 1'b1;
        quiet = moved ? 0 : quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    task automatic wait_drained();
        do @(posedge aclk);
        while (stream_items.size() != 0 || s_valid || smoothed_due.size() != 0);
    endtask

    task automatic write_tap_count(input logic [5:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk);
        while (!cfg_ready);
        model_taps = v;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        cfg_data  <= 6'($urandom);
    endtask

    // Mostly runs of samples and tail steps, with weight reloads and restarts mixed in.
    task automatic push_random_items(input int n);
        int          made;
        int          roll;
        int          run;
        int          pick;
        logic [15:0] v;
        made = 0;
        while (made < n) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) begin
                pick = $urandom_range(0, 19);
                v = (pick < 2) ? 16'd0 : ((pick == 2) ? 16'hFFFF : 16'($urandom));
                queue_item(make_item(OP_LOAD, 5'($urandom), v, 16'($urandom)));
                made++;
            end else if (roll < 22) begin
                run = $urandom_range(1, 4);
                repeat (run) begin
                    queue_item(make_item(OP_TAIL, 5'($urandom), 16'($urandom),
                                         16'($urandom)));
                end
                made += run;
            end else if (roll < 25) begin
                queue_item(make_item(OP_RESTART, 5'($urandom), 16'($urandom),
                                     16'($urandom)));
                made++;
            end else begin
                run = $urandom_range(1, 8);
                repeat (run) begin
                    pick = $urandom_range(0, 24);
                    v = (pick < 2) ? 16'd0 : ((pick < 4) ? 16'hFFFF : 16'($urandom));
                    queue_item(make_item(OP_SAMPLE, 5'($urandom), 16'($urandom), v));
                end
                made += run;
            end
        end
    endtask

    initial begin : run_phases
        logic [5:0] phase_taps [RANDOM_PHASES];
        idle_mode_t phase_mode [RANDOM_PHASES];
        logic [15:0] w;
        phase_taps = '{6'd0, 6'd63, 6'd33, 6'd7, 6'd32, 6'd1, 6'd20, 6'd2};
        phase_mode = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH,
                       IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
        for (int k = 0; k < TAP_LIMIT; k++) begin
            hist_val[k] = '0;
            hist_ok[k]  = 1'b0;
            tap_w[k]    = '0;
        end
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Single tap: every weight loaded first, then the extremes, a zero weight
        // on a present sample, and tail steps that leave no sample in reach.
        write_tap_count(6'd1);
        for (int k = 0; k < TAP_LIMIT; k++) begin
            w = (k == 0) ? 16'hFFFF : ((k == TAP_LIMIT - 1) ? 16'd0 : 16'($urandom));
            queue_item(make_item(OP_LOAD, 5'(k), w, 16'($urandom)));
        end
        queue_item(make_item(OP_SAMPLE, 5'($urandom), 16'($urandom), 16'hFFFF));
        queue_item(make_item(OP_SAMPLE, 5'($urandom), 16'($urandom), 16'h0000));
        queue_item(make_item(OP_TAIL, 5'($urandom), 16'($urandom), 16'($urandom)));
        queue_item(make_item(OP_TAIL, 5'($urandom), 16'($urandom), 16'($urandom)));
        queue_item(make_item(OP_LOAD, 5'd0, 16'h0000, 16'($urandom)));
        queue_item(make_item(OP_SAMPLE, 5'($urandom), 16'($urandom), 16'h1234));
        queue_item(make_item(OP_LOAD, 5'd0, 16'hFFFF, 16'($urandom)));
        queue_item(make_item(OP_RESTART, 5'($urandom), 16'($urandom), 16'($urandom)));
        queue_item(make_item(OP_TAIL, 5'($urandom), 16'($urandom), 16'($urandom)));
        queue_item(make_item(OP_SAMPLE, 5'($urandom), 16'($urandom), 16'h8001));
        wait_drained();
        repeat (DRAIN_GAP) @(posedge aclk);

        // Full reach: full-scale history, a kernel tail, then a restart.
        write_tap_count(6'd32);
        repeat (3) begin
            queue_item(make_item(OP_SAMPLE, 5'($urandom), 16'($urandom), 16'hFFFF));
        end
        queue_item(make_item(OP_SAMPLE, 5'($urandom), 16'($urandom), 16'h0000));
        repeat (2) begin
            queue_item(make_item(OP_TAIL, 5'($urandom), 16'($urandom), 16'($urandom)));
        end
        queue_item(make_item(OP_RESTART, 5'($urandom), 16'($urandom), 16'($urandom)));
        queue_item(make_item(OP_SAMPLE, 5'($urandom), 16'($urandom), 16'hAAAA));
        queue_item(make_item(OP_SAMPLE, 5'($urandom), 16'($urandom), 16'h5555));
        queue_item(make_item(OP_TAIL, 5'($urandom), 16'($urandom), 16'($urandom)));
        wait_drained();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            repeat (DRAIN_GAP) @(posedge aclk);
            write_tap_count(phase_taps[p]);
            idle_mode = phase_mode[p];
            push_random_items(PHASE_ITEMS);
            cur_phase = p;
            wait_drained();
        end

        repeat (DRAIN_GAP) @(posedge aclk);
        $display("Run covered %0d input transfers and %0d checked results (%0d zero, %0d tail).",
                 accepted_cnt, results_seen, zero_results, tail_results);
        $display("%0d tap_count writes from 0 to 63, idle and stall phases, one long hold-off.",
                 cfg_writes);
        if (err_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
